// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the stable max-priority queue.
package spq_pkg;

  // Store depth and derived widths
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SEV_W    = 16;
  localparam int unsigned ENT_W    = TAG_W + SEV_W;

  // Command codes (bit 1 set means clear)
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SERVE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_SERVED   = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;       // item taken this cycle
    logic scan_step;    // compare one entry, fetch the next
    logic shift_start;  // fetch the entry after the winner
    logic shift_step;   // move one entry down, fetch the next
    logic finish;       // drop count, emit the served item
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic serve_go;     // accepted item is a serve on a non-empty store
    logic scan_last;    // entry under compare is the last one
    logic shift_none;   // nothing above the winner to move
    logic shift_last;   // last entry is being moved
  } dp_stat_t;

endpackage

// ----- rtl/core/spq_ctrl.sv -----
// Sequencer for the serve path: scan, shift and finish.
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::dp_stat_t stat_i,
  output spq_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHSTRT = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = start;
        if (start && stat_i.serve_go) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_SHSTRT;
        end
      end
      S_SHSTRT: begin
        cmd_o.shift_start = 1'b1;
        state_d = stat_i.shift_none ? S_FINISH : S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/spq_dp.sv -----
// Entry store in arrival order, max search, compaction and result register.
module spq_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::dp_cmd_t          cmd_i,
  output spq_pkg::dp_stat_t         stat_o,
  input  logic [1:0]                command_i,
  input  logic [spq_pkg::TAG_W-1:0] tag_i,
  input  logic [spq_pkg::SEV_W-1:0] severity_i,
  output logic                      done_o,
  output logic [spq_pkg::TAG_W-1:0] served_tag_o,
  output logic [2:0]                status_o
);

  // Entry store: severity in the upper half, tag in the lower half
  logic [spq_pkg::ENT_W-1:0] mem [spq_pkg::CAPACITY];
  logic [spq_pkg::ENT_W-1:0] rd_data_q;
  logic [spq_pkg::IDX_W-1:0] rd_addr;
  logic                      rd_en;
  logic [spq_pkg::IDX_W-1:0] wr_addr;
  logic [spq_pkg::ENT_W-1:0] wr_data;
  logic                      wr_en;

  logic [spq_pkg::CNT_W-1:0] cnt_q;
  logic [spq_pkg::IDX_W-1:0] ci_q;      // index under compare
  logic [spq_pkg::CNT_W-1:0] sh_q;      // index whose data is in rd_data_q
  logic [spq_pkg::IDX_W-1:0] best_q;
  logic [spq_pkg::SEV_W-1:0] best_sev_q;
  logic [spq_pkg::TAG_W-1:0] best_tag_q;

  logic                      done_q;
  logic [spq_pkg::TAG_W-1:0] res_tag_q;
  logic [2:0]                res_st_q;

  logic                      is_clear, is_insert, full, empty, take;
  logic [spq_pkg::SEV_W-1:0] rd_sev;
  logic [spq_pkg::CNT_W-1:0] best_nx, sh_nx, cnt_m1;

  assign is_clear  = command_i[1];
  assign is_insert = (command_i == spq_pkg::CMD_INSERT);
  assign full      = (cnt_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty     = (cnt_q == '0);
  assign rd_sev    = rd_data_q[spq_pkg::ENT_W-1:spq_pkg::TAG_W];
  assign best_nx   = {1'b0, best_q} + spq_pkg::CNT_W'(1);
  assign sh_nx     = sh_q + spq_pkg::CNT_W'(1);
  assign cnt_m1    = cnt_q - spq_pkg::CNT_W'(1);
  // strict greater keeps the earliest arrival among equal severities
  assign take      = (ci_q == '0) || (rd_sev > best_sev_q);

  // Status to the sequencer
  assign stat_o.serve_go   = (command_i == spq_pkg::CMD_SERVE) && !empty;
  assign stat_o.scan_last  = ({1'b0, ci_q} == cnt_m1);
  assign stat_o.shift_none = (best_nx >= cnt_q);
  assign stat_o.shift_last = (sh_nx >= cnt_q);

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = cnt_q[spq_pkg::IDX_W-1:0];
    wr_data = {severity_i, tag_i};
    if (cmd_i.accept && stat_o.serve_go) begin
      rd_en = 1'b1;
    end
    if (cmd_i.accept && !is_clear && is_insert && !full) begin
      wr_en = 1'b1;
    end
    if (cmd_i.scan_step) begin
      rd_en   = 1'b1;
      rd_addr = ci_q + spq_pkg::IDX_W'(1);
    end
    if (cmd_i.shift_start) begin
      rd_en   = 1'b1;
      rd_addr = best_nx[spq_pkg::IDX_W-1:0];
    end
    if (cmd_i.shift_step) begin
      rd_en   = 1'b1;
      rd_addr = sh_nx[spq_pkg::IDX_W-1:0];
      wr_en   = 1'b1;
      wr_addr = sh_q[spq_pkg::IDX_W-1:0] - spq_pkg::IDX_W'(1);
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Scan and shift bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ci_q <= '0;
    end
    if (cmd_i.scan_step) begin
      ci_q <= ci_q + spq_pkg::IDX_W'(1);
      if (take) begin
        best_q     <= ci_q;
        best_sev_q <= rd_sev;
        best_tag_q <= rd_data_q[spq_pkg::TAG_W-1:0];
      end
    end
    if (cmd_i.shift_start) begin
      sh_q <= best_nx;
    end
    if (cmd_i.shift_step) begin
      sh_q <= sh_nx;
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.accept && is_clear) begin
      cnt_q <= '0;
    end else if (cmd_i.accept && is_insert && !full) begin
      cnt_q <= cnt_q + spq_pkg::CNT_W'(1);
    end else if (cmd_i.finish) begin
      cnt_q <= cnt_m1;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.accept && !stat_o.serve_go) || cmd_i.finish;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_tag_q <= '0;
      if (is_clear) begin
        res_st_q <= spq_pkg::ST_CLEARED;
      end else if (is_insert) begin
        res_st_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end else begin
        res_st_q <= spq_pkg::ST_EMPTY;
      end
    end else if (cmd_i.finish) begin
      res_tag_q <= best_tag_q;
      res_st_q  <= spq_pkg::ST_SERVED;
    end
  end

  assign done_o       = done_q;
  assign served_tag_o = res_tag_q;
  assign status_o     = res_st_q;

endmodule

// ----- rtl/core/stable_max_priority_queue_unit.sv -----
// Insert, clear, full and empty: result strobe in the cycle after start, next item at once.
// Serve: busy as it scans every entry, shifts each one above the winner and finishes,
// paced by a scan through the store's single read port and entry-by-entry compaction.
// No new item is taken while busy; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the queue; store contents need no clearing.
module stable_max_priority_queue_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command_i,
  input  logic [spq_pkg::TAG_W-1:0] tag_i,
  input  logic [spq_pkg::SEV_W-1:0] severity_i,
  output logic                      done_o,
  output logic [spq_pkg::TAG_W-1:0] served_tag_o,
  output logic [2:0]                status_o
);

  spq_pkg::dp_cmd_t  dp_cmd;
  spq_pkg::dp_stat_t dp_stat;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  // Store and result datapath
  spq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .command_i    (command_i),
    .tag_i        (tag_i),
    .severity_i   (severity_i),
    .done_o       (done_o),
    .served_tag_o (served_tag_o),
    .status_o     (status_o)
  );

endmodule

// ----- bench/tb_stable_max_priority_queue_unit.sv -----
// Self-checking testbench for the stable max-priority queue: directed table, then random traffic.
module tb_stable_max_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         CLK_PERIOD   = 4ns;
  localparam int unsigned LIMIT_CYCLES = 5_000_000;
  localparam int unsigned ITEM_TARGET  = 1700;
  localparam int unsigned SETTLE_CYC   = 16;
  // Code three decodes like clear
  localparam logic [1:0]  CMD_CLEAR_ALT = 2'd3;

  // One stored entry, kept in insertion order
  typedef struct packed {
    logic [spq_pkg::TAG_W-1:0] tag;
    logic [spq_pkg::SEV_W-1:0] sev;
    logic [31:0]               stamp;
  } entry_t;

  // One result of the block
  typedef struct packed {
    logic [spq_pkg::TAG_W-1:0] tag;
    logic [2:0]                status;
  } outcome_t;

  // One row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    logic [1:0]                cmd;
    logic [spq_pkg::TAG_W-1:0] tag;
    logic [spq_pkg::SEV_W-1:0] sev;
    logic                      typed;
    logic [spq_pkg::TAG_W-1:0] etag;
    logic [2:0]                est;
  } row_t;

  localparam int unsigned NUM_ROWS = 24;
  localparam row_t SCRIPT [NUM_ROWS] = '{
    // serve after reset
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b1, 16'h0000, spq_pkg::ST_EMPTY},
    '{spq_pkg::CMD_CLEAR,  16'h0000, 16'h0000, 1'b1, 16'h0000, spq_pkg::ST_CLEARED},
    // lowest severity, highest severity, then a later tie
    '{spq_pkg::CMD_INSERT, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_INSERT, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_INSERT, 16'h1234, 16'hFFFF, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_INSERT, 16'h5555, 16'h8000, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_SERVE,  16'hAAAA, 16'h5555, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    // drained
    '{spq_pkg::CMD_SERVE,  16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, spq_pkg::ST_EMPTY},
    '{spq_pkg::CMD_INSERT, 16'hAAAA, 16'h0000, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_INSERT, 16'h5555, 16'h0000, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    // code three
    '{CMD_CLEAR_ALT,       16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, spq_pkg::ST_CLEARED},
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b1, 16'h0000, spq_pkg::ST_EMPTY},
    '{spq_pkg::CMD_INSERT, 16'h0001, 16'h0007, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_INSERT, 16'h0002, 16'h0007, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_INSERT, 16'h0003, 16'h0009, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_SERVE,  16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    '{spq_pkg::CMD_INSERT, 16'h0004, 16'h0007, 1'b1, 16'h0000, spq_pkg::ST_INSERTED},
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    '{spq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 1'b0, 16'h0000, spq_pkg::ST_SERVED},
    '{spq_pkg::CMD_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, spq_pkg::ST_CLEARED}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [1:0]                command_i;
  logic [spq_pkg::TAG_W-1:0] tag_i;
  logic [spq_pkg::SEV_W-1:0] severity_i;
  logic                      done_o;
  logic [spq_pkg::TAG_W-1:0] served_tag_o;
  logic [2:0]                status_o;

  // Queue state as the block should hold it
  entry_t      held_entries[$];
  logic [31:0] arrival_count;
  outcome_t    pending_outcomes[$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned idle_pct;
  longint unsigned cycle_count;

  stable_max_priority_queue_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .tag_i        (tag_i),
    .severity_i   (severity_i),
    .done_o       (done_o),
    .served_tag_o (served_tag_o),
    .status_o     (status_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result of one command, updating the held queue
  function automatic outcome_t predict_outcome(input logic [1:0] cmd,
                                               input logic [spq_pkg::TAG_W-1:0] tag,
                                               input logic [spq_pkg::SEV_W-1:0] sev);
    outcome_t res;
    entry_t   ent;
    int       best;
    res.tag = '0;
    if (cmd[1]) begin
      held_entries.delete();
      arrival_count = '0;
      res.status = spq_pkg::ST_CLEARED;
    end else if (cmd == spq_pkg::CMD_INSERT) begin
      if (held_entries.size() >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        ent.tag   = tag;
        ent.sev   = sev;
        ent.stamp = arrival_count;
        held_entries.push_back(ent);
        arrival_count = arrival_count + 1;
        res.status = spq_pkg::ST_INSERTED;
      end
    end else if (held_entries.size() == 0) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      // strict compare keeps the oldest among equal severities
      best = 0;
      for (int i = 1; i < held_entries.size(); i++) begin
        if (held_entries[i].sev > held_entries[best].sev) best = i;
      end
      res.tag    = held_entries[best].tag;
      res.status = spq_pkg::ST_SERVED;
      held_entries.delete(best);
    end
    return res;
  endfunction

  // Sender holds start low, fields wander
  task automatic sit_idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start      <= 1'b0;
      command_i  <= 2'($urandom);
      tag_i      <= 16'($urandom);
      severity_i <= 16'($urandom);
    end
  endtask

  // Offer one item, wait for the handshake, record what should come back
  task automatic send_item(input logic [1:0] cmd, input logic [spq_pkg::TAG_W-1:0] tag,
                           input logic [spq_pkg::SEV_W-1:0] sev, input logic typed,
                           input outcome_t typed_res);
    outcome_t res;
    // each sender cycle idles with the regime's odds
    while ($urandom_range(99) < idle_pct) sit_idle(1);
    @(negedge clk_i);
    start      <= 1'b1;
    command_i  <= cmd;
    tag_i      <= tag;
    severity_i <= sev;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    res = predict_outcome(cmd, tag, sev);
    pending_outcomes.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic send_checked(input logic [1:0] cmd, input logic [spq_pkg::TAG_W-1:0] tag,
                              input logic [spq_pkg::SEV_W-1:0] sev);
    send_item(cmd, tag, sev, 1'b0, '0);
  endtask

  // Pause the sender until every outstanding result is back
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [spq_pkg::SEV_W-1:0] pick_severity(input int unsigned mode);
    case (mode)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(3));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // One random sequence: mostly insert runs followed by serves
  task automatic run_burst();
    int unsigned r, n, mode;
    r    = $urandom_range(99);
    n    = $urandom_range(1, 12);
    mode = $urandom_range(2);
    if (r < 8) begin
      // noise: any code, any fields
      repeat (n) send_checked(2'($urandom), 16'($urandom), 16'($urandom));
    end else if (r < 14) begin
      send_checked($urandom_range(1) ? spq_pkg::CMD_CLEAR : CMD_CLEAR_ALT,
                   16'($urandom), 16'($urandom));
    end else begin
      if (held_entries.size() < 48) begin
        repeat (n) send_checked(spq_pkg::CMD_INSERT, 16'($urandom), pick_severity(mode));
      end
      repeat ($urandom_range(0, n + 2)) begin
        // serve fields are ignored, drive junk
        send_checked(spq_pkg::CMD_SERVE, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // Fill past capacity, then drain past empty
  task automatic run_fill();
    send_checked(spq_pkg::CMD_CLEAR, '0, '0);
    repeat (spq_pkg::CAPACITY + 2) begin
      send_checked(spq_pkg::CMD_INSERT, 16'($urandom), 16'($urandom_range(15)));
    end
    repeat (spq_pkg::CAPACITY + 2) begin
      send_checked(spq_pkg::CMD_SERVE, 16'($urandom), 16'($urandom));
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: served_tag %h status %0d", served_tag_o, status_o);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (served_tag_o !== want.tag) begin
          $error("served_tag mismatch: expected %h, actual %h", want.tag, served_tag_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[stable_max_priority_queue_unit] ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    outcome_t typed_res;
    int unsigned phase_end;
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = spq_pkg::CMD_INSERT;
    tag_i          = '0;
    severity_i     = '0;
    arrival_count  = '0;
    mismatch_count = 0;
    items_sent     = 0;
    idle_pct       = 0;
    cycle_count    = 0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (SCRIPT[i]) begin
      typed_res.tag    = SCRIPT[i].etag;
      typed_res.status = SCRIPT[i].est;
      send_item(SCRIPT[i].cmd, SCRIPT[i].tag, SCRIPT[i].sev, SCRIPT[i].typed, typed_res);
    end
    wait_drained();

    // Random traffic in three sender idling regimes
    for (int p = 0; p < 3; p++) begin
      idle_pct  = (p == 0) ? 37 : (p == 1) ? 54 : 0;
      phase_end = NUM_ROWS + (ITEM_TARGET - NUM_ROWS) * (p + 1) / 3;
      if (p == 1) run_fill();
      while (items_sent < phase_end) begin
        run_burst();
        if ($urandom_range(19) == 0) wait_drained();
      end
      wait_drained();
    end

    // Quiet tail to catch stray strobes
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("[stable_max_priority_queue_unit] OK");
    end else begin
      $display("[stable_max_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule
